// ===== rtl/core/gps_pkg.sv =====
`timescale 1ns / 1ps
// shared types, register indexes and color arithmetic for the grid pixel shader
// no dependencies

package gps_pkg;

    localparam int COORD_INT_BITS = 16;
    localparam int REM_STEP       = 4;
    localparam int REM_STAGES     = COORD_INT_BITS / REM_STEP;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 32;

    localparam logic [7:0]  ALPHA_OPAQUE = 8'd255;
    localparam logic [31:0] MASK_RB      = 32'h00ff00ff;
    localparam logic [31:0] MASK_AG      = 32'hff00ff00;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_BOX_WIDTH     = 3'd0,
        REG_BOX_HEIGHT    = 3'd1,
        REG_BORDER_WIDTH  = 3'd2,
        REG_BORDER_HEIGHT = 3'd3,
        REG_BOX_COLOR     = 3'd4,
        REG_FRAME_COLOR   = 3'd5,
        REG_MASK_ENABLE   = 3'd6
    } cfg_reg_t;

    typedef enum logic [1:0] {
        BLEND_NONE,
        BLEND_LEAD,
        BLEND_TRAIL
    } blend_sel_t;

    typedef struct packed {
        logic signed [31:0] sample_x;
        logic signed [31:0] sample_y;
        logic [7:0]         mask_alpha;
    } sample_t;

    typedef struct packed {
        logic [31:0] pixel_color;
        logic        pixel_write;
    } pixel_t;

    typedef struct packed {
        logic [COORD_INT_BITS-1:0] mag_x;
        logic [COORD_INT_BITS-1:0] mag_y;
        logic                      neg_x;
        logic                      neg_y;
        logic [15:0]               frac_x;
        logic [15:0]               frac_y;
        logic [7:0]                ma;
    } div_ctl_t;

    typedef struct packed {
        logic       kill;
        blend_sel_t sel_x;
        blend_sel_t sel_y;
        logic [8:0] ax;
        logic [8:0] ay;
        logic [7:0] ma;
    } shade_ctl_t;

    typedef struct packed {
        logic [31:0] box_color;
        logic [31:0] frame_color;
    } colors_t;

    function automatic logic [31:0] lerp256(logic [8:0] a, logic [31:0] c0, logic [31:0] c1);
        logic [31:0] d_hi;
        logic [31:0] d_lo;
        logic [31:0] m_hi;
        logic [31:0] m_lo;
        logic [31:0] hi;
        logic [31:0] lo;
        d_hi = ((c0 >> 8) & MASK_RB) - ((c1 >> 8) & MASK_RB);
        d_lo = (c0 & MASK_RB) - (c1 & MASK_RB);
        m_hi = d_hi * {23'd0, a};
        m_lo = d_lo * {23'd0, a};
        hi   = (m_hi + (c1 & MASK_AG)) & MASK_AG;
        lo   = ((m_lo >> 8) + (c1 & MASK_RB)) & MASK_RB;
        return hi + lo;
    endfunction

    function automatic logic [31:0] scale_alpha(logic [7:0] ma, logic [31:0] c);
        logic [31:0] m_hi;
        logic [31:0] m_lo;
        m_hi = ((c >> 8) & MASK_RB) * {24'd0, ma};
        m_lo = (c & MASK_RB) * {24'd0, ma};
        return ((m_hi + MASK_RB) & MASK_AG) + (((m_lo + MASK_RB) >> 8) & MASK_RB);
    endfunction

endpackage

// ===== rtl/core/periodic_grid_pixel_shader_top.sv =====
`timescale 1ns / 1ps
// top level of the periodic grid pixel shader: config registers, input stage,
// remainder pipeline and shading pipeline; depends on gps_pkg, gps_mod_stage, gps_shade
//
//  channel | signals                              | kind
//  --------+--------------------------------------+-------------------------
//  sample  | sample_valid, sample_ready, sample   | in,  valid/ready transfer
//  pixel   | pixel_valid, pixel_ready, pixel      | out, valid/ready transfer
//  config  | cfg_write, cfg_index, cfg_data       | write only, no wait
//
// one pixel per clock unless the pixel port stalls; pipeline: input stage, 4 remainder stages
// (4 quotient bits per axis each), decode, column blend, row blend, mask scale
// every stage has its own valid bit and advances when empty or when its successor
// advances, so a stalled pixel port holds its result while bubbles fill up
// reset clears valid bits and loads the register reset values

module periodic_grid_pixel_shader_top
    import gps_pkg::*;
#(
    parameter int SIZE_BITS = 12
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      sample_valid,
    output logic                      sample_ready,
    input  sample_t                   sample,
    output logic                      pixel_valid,
    input  logic                      pixel_ready,
    output pixel_t                    pixel,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    logic [SIZE_BITS-1:0] box_width_reg;
    logic [SIZE_BITS-1:0] box_height_reg;
    logic [SIZE_BITS-1:0] border_width_reg;
    logic [SIZE_BITS-1:0] border_height_reg;
    colors_t              colors_reg;
    logic                 mask_enable_reg;
    logic [SIZE_BITS:0]   period_x;
    logic [SIZE_BITS:0]   period_y;

    logic                      in_valid_reg;
    div_ctl_t                  in_ctl_reg;
    div_ctl_t                  in_ctl_next;
    logic [COORD_INT_BITS-1:0] int_x;
    logic [COORD_INT_BITS-1:0] int_y;

    logic               st_valid [0:REM_STAGES];
    logic               st_ready [0:REM_STAGES];
    div_ctl_t           st_ctl   [0:REM_STAGES];
    logic [SIZE_BITS:0] st_rem_x [0:REM_STAGES];
    logic [SIZE_BITS:0] st_rem_y [0:REM_STAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_width_reg     <= {{(SIZE_BITS-1){1'b0}}, 1'b1};
            box_height_reg    <= {{(SIZE_BITS-1){1'b0}}, 1'b1};
            border_width_reg  <= {{(SIZE_BITS-1){1'b0}}, 1'b1};
            border_height_reg <= {{(SIZE_BITS-1){1'b0}}, 1'b1};
            colors_reg        <= '0;
            mask_enable_reg   <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_BOX_WIDTH:     box_width_reg     <= cfg_data[SIZE_BITS-1:0];
                REG_BOX_HEIGHT:    box_height_reg    <= cfg_data[SIZE_BITS-1:0];
                REG_BORDER_WIDTH:  border_width_reg  <= cfg_data[SIZE_BITS-1:0];
                REG_BORDER_HEIGHT: border_height_reg <= cfg_data[SIZE_BITS-1:0];
                REG_BOX_COLOR:     colors_reg.box_color   <= cfg_data[31:0];
                REG_FRAME_COLOR:   colors_reg.frame_color <= cfg_data[31:0];
                REG_MASK_ENABLE:   mask_enable_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign period_x = {1'b0, box_width_reg} + {1'b0, border_width_reg};
    assign period_y = {1'b0, box_height_reg} + {1'b0, border_height_reg};

    // split into sign, integer magnitude and fraction
    always_comb
    begin
        int_x = sample.sample_x[31:16];
        int_y = sample.sample_y[31:16];
        in_ctl_next.neg_x  = int_x[COORD_INT_BITS-1];
        in_ctl_next.neg_y  = int_y[COORD_INT_BITS-1];
        in_ctl_next.mag_x  = int_x[COORD_INT_BITS-1] ? (~int_x + 1'b1) : int_x;
        in_ctl_next.mag_y  = int_y[COORD_INT_BITS-1] ? (~int_y + 1'b1) : int_y;
        in_ctl_next.frac_x = sample.sample_x[15:0];
        in_ctl_next.frac_y = sample.sample_y[15:0];
        in_ctl_next.ma     = mask_enable_reg ? sample.mask_alpha : ALPHA_OPAQUE;
    end

    assign sample_ready = !in_valid_reg || st_ready[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (sample_ready)
        begin
            in_valid_reg <= sample_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_ready && sample_valid)
        begin
            in_ctl_reg <= in_ctl_next;
        end
    end

    assign st_valid[0] = in_valid_reg;
    assign st_ctl[0]   = in_ctl_reg;
    assign st_rem_x[0] = '0;
    assign st_rem_y[0] = '0;

    for (genvar i = 0; i < REM_STAGES; i++)
    begin : g_rem
        gps_mod_stage #(
            .SIZE_BITS (SIZE_BITS)
        ) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (st_valid[i]),
            .up_ready (st_ready[i]),
            .up_ctl   (st_ctl[i]),
            .up_rem_x (st_rem_x[i]),
            .up_rem_y (st_rem_y[i]),
            .period_x (period_x),
            .period_y (period_y),
            .dn_valid (st_valid[i+1]),
            .dn_ready (st_ready[i+1]),
            .dn_ctl   (st_ctl[i+1]),
            .dn_rem_x (st_rem_x[i+1]),
            .dn_rem_y (st_rem_y[i+1])
        );
    end

    gps_shade #(
        .SIZE_BITS (SIZE_BITS)
    ) u_shade (
        .clk           (clk),
        .rst_n         (rst_n),
        .up_valid      (st_valid[REM_STAGES]),
        .up_ready      (st_ready[REM_STAGES]),
        .up_ctl        (st_ctl[REM_STAGES]),
        .rem_x         (st_rem_x[REM_STAGES]),
        .rem_y         (st_rem_y[REM_STAGES]),
        .period_x      (period_x),
        .period_y      (period_y),
        .box_width     (box_width_reg),
        .box_height    (box_height_reg),
        .border_width  (border_width_reg),
        .border_height (border_height_reg),
        .colors        (colors_reg),
        .dn_valid      (pixel_valid),
        .dn_ready      (pixel_ready),
        .dn_pixel      (pixel)
    );

    // a suppressed pixel carries no color
    a_kill_zero: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && !pixel.pixel_write |-> pixel.pixel_color == '0)
        else $error("suppressed pixel with nonzero color");

    // backpressure only comes from a stalled pixel port
    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        !sample_ready |-> pixel_valid && !pixel_ready)
        else $error("input stalled without output stall");

    // without mask and with valid sizes every pixel is written
    a_write_on: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && !mask_enable_reg && box_width_reg != '0 &&
        box_height_reg != '0 && border_width_reg != '0 &&
        border_height_reg != '0 |-> pixel.pixel_write)
        else $error("pixel write dropped");

endmodule

// ===== rtl/core/gps_mod_stage.sv =====
`timescale 1ns / 1ps
// one pipeline stage of the coordinate remainder unit, a few quotient bits per axis
// depends on gps_pkg

module gps_mod_stage
    import gps_pkg::*;
#(
    parameter int SIZE_BITS = 12
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               up_valid,
    output logic               up_ready,
    input  div_ctl_t           up_ctl,
    input  logic [SIZE_BITS:0] up_rem_x,
    input  logic [SIZE_BITS:0] up_rem_y,
    input  logic [SIZE_BITS:0] period_x,
    input  logic [SIZE_BITS:0] period_y,
    output logic               dn_valid,
    input  logic               dn_ready,
    output div_ctl_t           dn_ctl,
    output logic [SIZE_BITS:0] dn_rem_x,
    output logic [SIZE_BITS:0] dn_rem_y
);

    logic                 valid_reg;
    div_ctl_t             ctl_reg;
    div_ctl_t             ctl_next;
    logic [SIZE_BITS:0]   rem_x_reg;
    logic [SIZE_BITS:0]   rem_y_reg;
    logic [SIZE_BITS:0]   rem_x_next;
    logic [SIZE_BITS:0]   rem_y_next;
    logic [SIZE_BITS+1:0] tx;
    logic [SIZE_BITS+1:0] ty;

    assign up_ready = !valid_reg || dn_ready;

    always_comb
    begin
        rem_x_next = up_rem_x;
        rem_y_next = up_rem_y;
        tx = '0;
        ty = '0;
        for (int k = 0; k < REM_STEP; k++)
        begin
            tx = {rem_x_next, up_ctl.mag_x[COORD_INT_BITS-1-k]};
            if (tx >= {1'b0, period_x})
            begin
                tx = tx - {1'b0, period_x};
            end
            rem_x_next = tx[SIZE_BITS:0];
            ty = {rem_y_next, up_ctl.mag_y[COORD_INT_BITS-1-k]};
            if (ty >= {1'b0, period_y})
            begin
                ty = ty - {1'b0, period_y};
            end
            rem_y_next = ty[SIZE_BITS:0];
        end
        ctl_next       = up_ctl;
        ctl_next.mag_x = {up_ctl.mag_x[COORD_INT_BITS-REM_STEP-1:0], {REM_STEP{1'b0}}};
        ctl_next.mag_y = {up_ctl.mag_y[COORD_INT_BITS-REM_STEP-1:0], {REM_STEP{1'b0}}};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            ctl_reg   <= ctl_next;
            rem_x_reg <= rem_x_next;
            rem_y_reg <= rem_y_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_ctl   = ctl_reg;
    assign dn_rem_x = rem_x_reg;
    assign dn_rem_y = rem_y_reg;

endmodule

// ===== rtl/core/gps_shade.sv =====
`timescale 1ns / 1ps
// shading pipeline: cell position decode, column blend, row blend, mask scale
// depends on gps_pkg

module gps_shade
    import gps_pkg::*;
#(
    parameter int SIZE_BITS = 12
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 up_valid,
    output logic                 up_ready,
    input  div_ctl_t             up_ctl,
    input  logic [SIZE_BITS:0]   rem_x,
    input  logic [SIZE_BITS:0]   rem_y,
    input  logic [SIZE_BITS:0]   period_x,
    input  logic [SIZE_BITS:0]   period_y,
    input  logic [SIZE_BITS-1:0] box_width,
    input  logic [SIZE_BITS-1:0] box_height,
    input  logic [SIZE_BITS-1:0] border_width,
    input  logic [SIZE_BITS-1:0] border_height,
    input  colors_t              colors,
    output logic                 dn_valid,
    input  logic                 dn_ready,
    output pixel_t               dn_pixel
);

    logic               vr_reg;
    logic               vx_reg;
    logic               vy_reg;
    logic               vo_reg;
    logic               rdy_r;
    logic               rdy_x;
    logic               rdy_y;
    logic               rdy_o;
    shade_ctl_t         r_ctl_reg;
    shade_ctl_t         r_ctl_next;
    shade_ctl_t         x_ctl_reg;
    shade_ctl_t         y_ctl_reg;
    logic [31:0]        r_color_reg;
    logic [31:0]        r_color_next;
    logic [31:0]        x_color_reg;
    logic [31:0]        x_color_next;
    logic [31:0]        y_color_reg;
    logic [31:0]        y_color_next;
    pixel_t             pix_reg;
    pixel_t             pix_next;
    logic [SIZE_BITS:0] rxi;
    logic [SIZE_BITS:0] ryi;
    logic [SIZE_BITS:0] w_ext;
    logic [SIZE_BITS:0] h_ext;
    logic               border;

    assign rdy_o    = !vo_reg || dn_ready;
    assign rdy_y    = !vy_reg || rdy_o;
    assign rdy_x    = !vx_reg || rdy_y;
    assign rdy_r    = !vr_reg || rdy_x;
    assign up_ready = rdy_r;

    // position decode
    always_comb
    begin
        rxi    = (up_ctl.neg_x && rem_x != '0) ? period_x - rem_x : rem_x;
        ryi    = (up_ctl.neg_y && rem_y != '0) ? period_y - rem_y : rem_y;
        w_ext  = {1'b0, box_width};
        h_ext  = {1'b0, box_height};
        border = (rxi >= w_ext) || (ryi >= h_ext);
        r_ctl_next.kill = (box_width == '0) || (box_height == '0) ||
                          (border_width == '0) || (border_height == '0) ||
                          (up_ctl.ma == '0);
        r_ctl_next.ma = up_ctl.ma;
        r_ctl_next.ax = {1'b0, up_ctl.frac_x[15:8]} + 9'd1;
        r_ctl_next.ay = {1'b0, up_ctl.frac_y[15:8]} + 9'd1;
        r_ctl_next.sel_x = BLEND_NONE;
        r_ctl_next.sel_y = BLEND_NONE;
        if (!border)
        begin
            if (rxi == '0)
            begin
                r_ctl_next.sel_x = BLEND_LEAD;
            end
            else if (rxi == w_ext - {{SIZE_BITS{1'b0}}, 1'b1})
            begin
                r_ctl_next.sel_x = BLEND_TRAIL;
            end
            if (ryi == '0)
            begin
                r_ctl_next.sel_y = BLEND_LEAD;
            end
            else if (ryi == h_ext - {{SIZE_BITS{1'b0}}, 1'b1})
            begin
                r_ctl_next.sel_y = BLEND_TRAIL;
            end
        end
        r_color_next = border ? colors.frame_color : colors.box_color;
    end

    always_comb
    begin
        case (r_ctl_reg.sel_x)
            BLEND_LEAD:  x_color_next = lerp256(r_ctl_reg.ax, r_color_reg, colors.frame_color);
            BLEND_TRAIL: x_color_next = lerp256(r_ctl_reg.ax, colors.frame_color, r_color_reg);
            default:     x_color_next = r_color_reg;
        endcase
    end

    always_comb
    begin
        case (x_ctl_reg.sel_y)
            BLEND_LEAD:  y_color_next = lerp256(x_ctl_reg.ay, x_color_reg, colors.frame_color);
            BLEND_TRAIL: y_color_next = lerp256(x_ctl_reg.ay, colors.frame_color, x_color_reg);
            default:     y_color_next = x_color_reg;
        endcase
    end

    always_comb
    begin
        if (y_ctl_reg.kill)
        begin
            pix_next.pixel_color = '0;
            pix_next.pixel_write = 1'b0;
        end
        else
        begin
            pix_next.pixel_color = (y_ctl_reg.ma != ALPHA_OPAQUE) ?
                                   scale_alpha(y_ctl_reg.ma, y_color_reg) : y_color_reg;
            pix_next.pixel_write = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vr_reg <= 1'b0;
            vx_reg <= 1'b0;
            vy_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (rdy_r)
            begin
                vr_reg <= up_valid;
            end
            if (rdy_x)
            begin
                vx_reg <= vr_reg;
            end
            if (rdy_y)
            begin
                vy_reg <= vx_reg;
            end
            if (rdy_o)
            begin
                vo_reg <= vy_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_r && up_valid)
        begin
            r_ctl_reg   <= r_ctl_next;
            r_color_reg <= r_color_next;
        end
        if (rdy_x && vr_reg)
        begin
            x_ctl_reg   <= r_ctl_reg;
            x_color_reg <= x_color_next;
        end
        if (rdy_y && vx_reg)
        begin
            y_ctl_reg   <= x_ctl_reg;
            y_color_reg <= y_color_next;
        end
        if (rdy_o && vy_reg)
        begin
            pix_reg <= pix_next;
        end
    end

    assign dn_valid = vo_reg;
    assign dn_pixel = pix_reg;

endmodule
